### rtl/core/stbl_pkg.sv
// ============================================================================
// Slot table package
// Shared widths, defaults and the register address for the slot table.
// ============================================================================
`default_nettype none

package stbl_pkg;

    localparam int SLOTS_DEFAULT       = 64;
    localparam int HANDLE_BITS_DEFAULT = 16;
    localparam int AGE_BITS_DEFAULT    = 32;

    localparam int HANDLE_PORT_W = 16;
    localparam int INDEX_PORT_W  = 6;
    localparam int COUNT_PORT_W  = 7;
    localparam int ACTIVE_W      = 7;
    localparam int PADDR_W       = 3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;
    localparam logic [PADDR_W-1:0]  ADDR_ACTIVE  = 3'd0;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

endpackage

`default_nettype wire

### rtl/core/stbl_cell.sv
// ============================================================================
// Slot table cell
// Holds one slot's handle and age and passes them to its neighbor on shift.
// ============================================================================
`default_nettype none

module stbl_cell #(
    parameter int HANDLE_BITS = 16,
    parameter int AGE_BITS    = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   shift,
    input  wire logic [HANDLE_BITS-1:0] handle_in,
    input  wire logic [AGE_BITS-1:0]    age_in,
    output logic      [HANDLE_BITS-1:0] handle_out,
    output logic      [AGE_BITS-1:0]    age_out
);

    logic [HANDLE_BITS-1:0] handle_reg;
    logic [AGE_BITS-1:0]    age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_reg <= '0;
            age_reg    <= '0;
        end
        else if (shift)
        begin
            handle_reg <= handle_in;
            age_reg    <= age_in;
        end
    end

    assign handle_out = handle_reg;
    assign age_out    = age_reg;

endmodule

`default_nettype wire

### rtl/core/slot_table_oldest_replace.sv
// ============================================================================
// Slot table with oldest-entry replacement
// Ring of slot cells rotated past one update unit at the head.
// ============================================================================
// A word is accepted when start is high and busy is low; op selects add or
// remove of handle. The slots form a ring that rotates one place per cycle
// while busy, so each slot passes the update unit once per pass.
// An add or a remove takes one pass; an add that finds no empty slot takes
// a second pass to replace the oldest entry. A word with handle zero or with
// no active slots completes at once. The result word is shown for exactly
// one cycle with done high, after the last pass ends or, for a rejected
// word, in the cycle after start. busy stays high during the passes. The
// receiver cannot stall the result. Reset empties every slot, clears the
// count and sets active_slots to 64. The APB port holds active_slots at
// address 0.
// ============================================================================
`default_nettype none

module slot_table_oldest_replace #(
    parameter int SLOTS       = stbl_pkg::SLOTS_DEFAULT,
    parameter int HANDLE_BITS = stbl_pkg::HANDLE_BITS_DEFAULT,
    parameter int AGE_BITS    = stbl_pkg::AGE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [stbl_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                op,
    input  wire logic [stbl_pkg::HANDLE_PORT_W-1:0]  handle,
    output logic                                     done,
    output logic                                     ok,
    output logic      [stbl_pkg::INDEX_PORT_W-1:0]   slot_index,
    output logic                                     evicted_valid,
    output logic      [stbl_pkg::HANDLE_PORT_W-1:0]  evicted_handle,
    output logic      [stbl_pkg::COUNT_PORT_W-1:0]   element_count
);

    import stbl_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2
    } state_t;

    state_t                 state_reg;
    logic [ACTIVE_W-1:0]    active_reg;
    logic                   op_reg;
    logic [HANDLE_BITS-1:0] h_reg;
    logic [CW-1:0]          n_reg;
    logic [IW-1:0]          pos_reg;
    logic                   hit_reg;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          best_reg;
    logic [AGE_BITS-1:0]    best_age_reg;
    logic [HANDLE_BITS-1:0] evh_reg;
    logic [CW-1:0]          count_reg;
    logic                   done_reg;
    logic                   ok_reg;
    logic [IW-1:0]          oidx_reg;
    logic                   oev_reg;
    logic [HANDLE_BITS-1:0] oevh_reg;

    logic [HANDLE_BITS-1:0] cell_h   [SLOTS];
    logic [AGE_BITS-1:0]    cell_a   [SLOTS];
    logic [HANDLE_BITS-1:0] tail_h;
    logic [AGE_BITS-1:0]    tail_a;
    logic                   shift;
    logic [HANDLE_BITS-1:0] h_in;
    logic [CW-1:0]          n_in;
    logic                   in_range;
    logic [AGE_BITS-1:0]    aged;
    logic                   last;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_ACTIVE);
    assign prdata    = (paddr == ADDR_ACTIVE) ? {{(32-ACTIVE_W){1'b0}}, active_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_write)
        begin
            active_reg <= pwdata[ACTIVE_W-1:0];
        end
    end

    assign h_in = HANDLE_BITS'(handle);

    always_comb
    begin
        if (32'(active_reg) > SLOTS)
        begin
            n_in = CW'(SLOTS);
        end
        else
        begin
            n_in = CW'(active_reg);
        end
    end

    assign shift    = (state_reg == ST_PASS1) || (state_reg == ST_PASS2);
    assign in_range = (CW'(pos_reg) < n_reg);
    assign aged     = (cell_a[0] == '1) ? cell_a[0] : cell_a[0] + 1'b1;
    assign last     = (pos_reg == IW'(SLOTS - 1));

    always_comb
    begin
        tail_h = cell_h[0];
        tail_a = cell_a[0];
        if (state_reg == ST_PASS1 && in_range)
        begin
            if (op_reg == OP_ADD)
            begin
                if (cell_h[0] == '0 && !hit_reg)
                begin
                    tail_h = h_reg;
                    tail_a = '0;
                end
                else if (cell_h[0] != '0)
                begin
                    tail_a = aged;
                end
            end
            else if (cell_h[0] == h_reg && !hit_reg)
            begin
                tail_h = '0;
                tail_a = '0;
            end
        end
        else if (state_reg == ST_PASS2 && pos_reg == best_reg)
        begin
            tail_h = h_reg;
            tail_a = '0;
        end
    end

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        if (k == SLOTS - 1)
        begin : g_tail
            stbl_cell #(.HANDLE_BITS(HANDLE_BITS), .AGE_BITS(AGE_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .handle_in  (tail_h),
                .age_in     (tail_a),
                .handle_out (cell_h[k]),
                .age_out    (cell_a[k])
            );
        end
        else
        begin : g_mid
            stbl_cell #(.HANDLE_BITS(HANDLE_BITS), .AGE_BITS(AGE_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .handle_in  (cell_h[k+1]),
                .age_in     (cell_a[k+1]),
                .handle_out (cell_h[k]),
                .age_out    (cell_a[k])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            oidx_reg     <= '0;
            oev_reg      <= 1'b0;
            oevh_reg     <= '0;
            op_reg       <= OP_ADD;
            h_reg        <= '0;
            n_reg        <= '0;
            pos_reg      <= '0;
            hit_reg      <= 1'b0;
            idx_reg      <= '0;
            best_reg     <= '0;
            best_age_reg <= '0;
            evh_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= op;
                        h_reg        <= h_in;
                        n_reg        <= n_in;
                        pos_reg      <= '0;
                        hit_reg      <= 1'b0;
                        idx_reg      <= '0;
                        best_reg     <= '0;
                        best_age_reg <= '0;
                        evh_reg      <= '0;
                        if (h_in == '0 || n_in == '0)
                        begin
                            done_reg <= 1'b1;
                            ok_reg   <= 1'b0;
                            oidx_reg <= '0;
                            oev_reg  <= 1'b0;
                            oevh_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_PASS1;
                        end
                    end
                end
                ST_PASS1:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (in_range)
                    begin
                        if (op_reg == OP_ADD)
                        begin
                            if (cell_h[0] == '0 && !hit_reg)
                            begin
                                hit_reg <= 1'b1;
                                idx_reg <= pos_reg;
                            end
                            else if (cell_h[0] != '0 && aged > best_age_reg)
                            begin
                                best_reg     <= pos_reg;
                                best_age_reg <= aged;
                            end
                        end
                        else if (cell_h[0] == h_reg && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                            idx_reg <= pos_reg;
                            evh_reg <= cell_h[0];
                        end
                    end
                    if (last)
                    begin
                        pos_reg <= '0;
                        if (op_reg == OP_ADD && !hit_reg && !(in_range && cell_h[0] == '0))
                        begin
                            state_reg <= ST_PASS2;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                            done_reg  <= 1'b1;
                            oev_reg   <= 1'b0;
                            if (op_reg == OP_ADD)
                            begin
                                ok_reg   <= 1'b1;
                                oevh_reg <= '0;
                                oidx_reg <= hit_reg ? idx_reg : pos_reg;
                                if (count_reg != CW'(SLOTS))
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            else if (hit_reg || (in_range && cell_h[0] == h_reg))
                            begin
                                ok_reg   <= 1'b1;
                                oidx_reg <= hit_reg ? idx_reg : pos_reg;
                                oevh_reg <= hit_reg ? evh_reg : cell_h[0];
                                if (count_reg != '0)
                                begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                ok_reg   <= 1'b0;
                                oidx_reg <= '0;
                                oevh_reg <= '0;
                            end
                        end
                    end
                end
                ST_PASS2:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (pos_reg == best_reg)
                    begin
                        evh_reg <= cell_h[0];
                    end
                    if (last)
                    begin
                        pos_reg   <= '0;
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                        ok_reg    <= 1'b1;
                        oev_reg   <= 1'b1;
                        oidx_reg  <= best_reg;
                        oevh_reg  <= (pos_reg == best_reg) ? cell_h[0] : evh_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign slot_index     = INDEX_PORT_W'(oidx_reg);
    assign evicted_valid  = oev_reg;
    assign evicted_handle = HANDLE_PORT_W'(oevh_reg);
    assign element_count  = COUNT_PORT_W'(count_reg);

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (slot_index == '0 && !evicted_valid && evicted_handle == '0))
        else $error("failed word carries data");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= SLOTS)
        else $error("occupied count above slot count");

    a_rotate_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !shift |=> ($stable(cell_h[0]) && $stable(cell_a[0])))
        else $error("slot changed while idle");
`endif

endmodule

`default_nettype wire
